// File: src/art_pkg.sv
`default_nettype none
package art_pkg;
    localparam int TIMER_SLOTS = 4;
    localparam int ALARM_SLOTS = 4;
    localparam int ALL_SLOTS   = TIMER_SLOTS + ALARM_SLOTS;
    localparam int SLOT_W      = $clog2(ALL_SLOTS);
    localparam int CNT_W       = $clog2(ALL_SLOTS + 1);

    localparam logic [2:0] OP_NOTE    = 3'd0;
    localparam logic [2:0] OP_PRESENT = 3'd1;
    localparam logic [2:0] OP_ACK     = 3'd2;
    localparam logic [2:0] OP_SNOOZE  = 3'd3;
    localparam logic [2:0] OP_REMOVE  = 3'd4;
    localparam logic [2:0] OP_ADVANCE = 3'd5;
    localparam logic [2:0] OP_SELECT  = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNCHANGED = 3'd1;
    localparam logic [2:0] ST_CONFLICT  = 3'd2;
    localparam logic [2:0] ST_ABSENT    = 3'd3;
    localparam logic [2:0] ST_INVALID   = 3'd4;
    localparam logic [2:0] ST_NOCAP     = 3'd5;

    localparam logic [1:0] RS_FREE       = 2'd0;
    localparam logic [1:0] RS_PENDING    = 2'd1;
    localparam logic [1:0] RS_PRESENTING = 2'd2;
    localparam logic [1:0] RS_SNOOZED    = 2'd3;

    localparam int TDATA_IN_W  = 264; // 261 bits of fields
    localparam int TDATA_OUT_W = 336; // 332 bits of fields

    typedef struct packed {
        logic [1:0]  src;
        logic [31:0] entity;
        logic [31:0] occ;
        logic [63:0] first_due;
        logic [63:0] last_utc;
        logic [63:0] snooze_due;
        logic [31:0] missed;
        logic [1:0]  rstate;
    } t_slot;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_APPLY, S_WAKE, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic apply;
        logic wake;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic wake_done;
    } t_stat;
endpackage
`default_nettype wire

// File: src/alert_record_table_core.sv
// channel | dir | payload
// s_axis  | in  | tdata: opcode, source, entity, occurrence, mono due, utc due, mono now
// m_axis  | out | tdata: status, woken_count, selected_* fields, revision_now
// cfg     | in  | snooze_interval_ms write
// An item is loaded, every slot is scanned, then the result is applied; an advance
// that wakes records walks all slots again; both walks go one slot a cycle. Then output.
// Reset clears every slot and sets the revision to 1; it is synchronous, active low.
// While a result waits for m_axis_tready, hold it and accept no new item.
`default_nettype none
module alert_record_table_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode, source, entity, occurrence, mono due, utc due, mono now
    input  wire [art_pkg::TDATA_IN_W-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // status, woken_count, selected_found, selected_source, selected_entity,
    // selected_occurrence, selected_state, selected_first_due, selected_last_utc,
    // selected_snooze_due, selected_missed, revision_now
    output logic [art_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    input  wire         i_cfg_we,
    input  wire [31:0]  i_cfg_data
);
    art_pkg::t_cmd  w_cmd;
    art_pkg::t_stat w_stat;
    logic           w_do_wake;

    art_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid(s_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(w_stat), .i_do_wake(w_do_wake), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .o_cmd(w_cmd)
    );

    art_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_data(s_axis_tdata), .i_cfg_we,
        .i_cfg_data, .o_stat(w_stat), .o_do_wake(w_do_wake), .o_data(m_axis_tdata)
    );

    a_one_hand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("in and out both open");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> s_axis_tready) else $error("no return to idle");
    a_woken_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[6:3] <= 4'(art_pkg::ALL_SLOTS))
        else $error("woken count too large");
endmodule
`default_nettype wire

// File: src/art_ctrl.sv
`default_nettype none
module art_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  wire            i_out_ready,
    input  wire art_pkg::t_stat i_stat,
    input  wire            i_do_wake,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output art_pkg::t_cmd  o_cmd
);
    art_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= art_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            art_pkg::S_IDLE:  if (i_in_valid) n_state = art_pkg::S_SCAN;
            art_pkg::S_SCAN:  if (i_stat.scan_done) n_state = art_pkg::S_APPLY;
            art_pkg::S_APPLY: n_state = i_do_wake ? art_pkg::S_WAKE : art_pkg::S_OUT;
            art_pkg::S_WAKE:  if (i_stat.wake_done) n_state = art_pkg::S_OUT;
            art_pkg::S_OUT:   if (i_out_ready) n_state = art_pkg::S_IDLE;
            default:          n_state = art_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == art_pkg::S_IDLE);
        o_out_valid = (r_state == art_pkg::S_OUT);
        o_cmd.load  = (r_state == art_pkg::S_IDLE) && i_in_valid;
        o_cmd.scan  = (r_state == art_pkg::S_SCAN);
        o_cmd.apply = (r_state == art_pkg::S_APPLY);
        o_cmd.wake  = (r_state == art_pkg::S_WAKE);
    end
endmodule
`default_nettype wire

// File: src/art_dp.sv
`default_nettype none
module art_dp (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire art_pkg::t_cmd i_cmd,
    input  wire [art_pkg::TDATA_IN_W-1:0] i_data,
    input  wire            i_cfg_we,
    input  wire [31:0]     i_cfg_data,
    output art_pkg::t_stat o_stat,
    output logic           o_do_wake,
    output logic [art_pkg::TDATA_OUT_W-1:0] o_data
);
    localparam int SW = art_pkg::SLOT_W;
    localparam int CW = art_pkg::CNT_W;

    art_pkg::t_slot r_slot [art_pkg::ALL_SLOTS];
    logic [31:0]  r_rev, r_intv;
    logic [2:0]   r_op;
    logic [1:0]   r_src;
    logic [31:0]  r_ent, r_occ;
    logic [63:0]  r_dm, r_du, r_now;
    logic [SW-1:0] r_idx;
    // lookup hit, first free, earliest live, due count
    logic          r_hit, r_free_ok, r_best_ok;
    logic [SW-1:0] r_hit_i, r_free_i, r_best_i;
    logic [CW-1:0] r_due;
    logic [2:0]    r_status;
    logic [3:0]    r_woken;
    logic          r_sel;

    logic [SW-1:0] w_i;
    art_pkg::t_slot w_c, w_b;
    logic          w_in_reg, w_better;
    logic          w_lo_reg;

    assign w_i = r_idx;
    assign w_c = r_slot[w_i];
    assign w_b = r_slot[r_best_i];
    assign w_lo_reg = (32'(r_idx) < 32'(art_pkg::TIMER_SLOTS));
    assign w_in_reg = (r_src == 2'd1 && w_lo_reg) || (r_src == 2'd2 && !w_lo_reg);
    assign w_better = (w_c.first_due < w_b.first_due) ||
        (w_c.first_due == w_b.first_due && (w_c.src < w_b.src ||
         (w_c.src == w_b.src && w_c.entity < w_b.entity)));

    assign o_stat.scan_done = (r_idx == SW'(art_pkg::ALL_SLOTS - 1));
    assign o_stat.wake_done = o_stat.scan_done;

    logic w_rev_max;
    logic [32:0] w_rev_sum;
    logic [64:0] w_snz;
    assign w_rev_max = (r_rev == 32'hFFFF_FFFF);
    assign w_rev_sum = {1'b0, r_rev} + 33'(r_due);
    assign w_snz     = {1'b0, r_now} + {33'd0, r_intv};
    assign o_do_wake = (r_op == art_pkg::OP_ADVANCE) && !w_rev_sum[32] && (r_due != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < art_pkg::ALL_SLOTS; k++) r_slot[k] <= '0;
            r_rev  <= 32'd1;
            r_intv <= 32'd300000;
            r_idx  <= '0;
        end else begin
            if (i_cfg_we) r_intv <= i_cfg_data;
            if (i_cmd.load) begin
                r_op  <= i_data[2:0];
                r_src <= i_data[4:3];
                r_ent <= i_data[36:5];
                r_occ <= i_data[68:37];
                r_dm  <= i_data[132:69];
                r_du  <= i_data[196:133];
                r_now <= i_data[260:197];
                r_idx <= '0;
                r_hit <= 1'b0; r_free_ok <= 1'b0; r_best_ok <= 1'b0;
                r_hit_i <= '0; r_free_i <= '0; r_best_i <= '0;
                r_due <= '0;
            end
            // walk one slot a cycle
            if (i_cmd.scan) begin
                r_idx <= o_stat.scan_done ? '0 : r_idx + 1'b1;
                if (w_in_reg && w_c.src == r_src && w_c.entity == r_ent && !r_hit) begin
                    r_hit <= 1'b1; r_hit_i <= w_i;
                end
                if (w_in_reg && w_c.src == 2'd0 && !r_free_ok) begin
                    r_free_ok <= 1'b1; r_free_i <= w_i;
                end
                if ((w_c.rstate == art_pkg::RS_PENDING ||
                     w_c.rstate == art_pkg::RS_PRESENTING) &&
                    (!r_best_ok || w_better)) begin
                    r_best_ok <= 1'b1; r_best_i <= w_i;
                end
                if (w_c.rstate == art_pkg::RS_SNOOZED && r_now >= w_c.snooze_due)
                    r_due <= r_due + 1'b1;
            end
            if (i_cmd.apply) begin
                r_woken <= o_do_wake ? 4'(r_due) : 4'd0;
                r_sel   <= (r_op == art_pkg::OP_SELECT) && r_best_ok;
                case (r_op) inside
                    art_pkg::OP_NOTE: begin
                        if (r_ent == '0 || r_occ == '0 || r_src == 2'd0 || r_src == 2'd3)
                            r_status <= art_pkg::ST_INVALID;
                        else if (r_hit && r_occ == r_slot[r_hit_i].occ)
                            r_status <= art_pkg::ST_UNCHANGED;
                        else if (r_hit && r_occ < r_slot[r_hit_i].occ)
                            r_status <= art_pkg::ST_CONFLICT;
                        else if (w_rev_max || (!r_hit && !r_free_ok))
                            r_status <= art_pkg::ST_NOCAP;
                        else if (r_hit) begin
                            if (r_slot[r_hit_i].missed != 32'hFFFF_FFFF)
                                r_slot[r_hit_i].missed <= r_slot[r_hit_i].missed + 1'b1;
                            r_slot[r_hit_i].occ <= r_occ;
                            r_slot[r_hit_i].last_utc <= r_du;
                            r_slot[r_hit_i].snooze_due <= '0;
                            r_slot[r_hit_i].rstate <= art_pkg::RS_PENDING;
                            r_rev <= r_rev + 1'b1;
                            r_status <= art_pkg::ST_OK;
                        end else begin
                            r_slot[r_free_i] <= '{src: r_src, entity: r_ent, occ: r_occ,
                                first_due: r_dm, last_utc: r_du, snooze_due: 64'd0,
                                missed: 32'd0, rstate: art_pkg::RS_PENDING};
                            r_rev <= r_rev + 1'b1;
                            r_status <= art_pkg::ST_OK;
                        end
                    end
                    art_pkg::OP_PRESENT, art_pkg::OP_ACK, art_pkg::OP_SNOOZE,
                    art_pkg::OP_REMOVE: begin
                        if (r_ent == '0 || (r_op != art_pkg::OP_REMOVE && r_occ == '0))
                            r_status <= art_pkg::ST_INVALID;
                        else if (!r_hit)
                            r_status <= art_pkg::ST_ABSENT;
                        else if (r_op != art_pkg::OP_REMOVE && r_slot[r_hit_i].occ != r_occ)
                            r_status <= art_pkg::ST_CONFLICT;
                        else if (r_op == art_pkg::OP_PRESENT) begin
                            if (r_slot[r_hit_i].rstate == art_pkg::RS_PRESENTING)
                                r_status <= art_pkg::ST_UNCHANGED;
                            else if (r_slot[r_hit_i].rstate != art_pkg::RS_PENDING)
                                r_status <= art_pkg::ST_CONFLICT;
                            else if (w_rev_max) r_status <= art_pkg::ST_NOCAP;
                            else begin
                                r_slot[r_hit_i].rstate <= art_pkg::RS_PRESENTING;
                                r_rev <= r_rev + 1'b1;
                                r_status <= art_pkg::ST_OK;
                            end
                        end else if (r_op == art_pkg::OP_SNOOZE) begin
                            if (r_slot[r_hit_i].rstate == art_pkg::RS_SNOOZED)
                                r_status <= art_pkg::ST_UNCHANGED;
                            else if (w_snz[64] || w_rev_max) r_status <= art_pkg::ST_NOCAP;
                            else begin
                                r_slot[r_hit_i].snooze_due <= w_snz[63:0];
                                r_slot[r_hit_i].rstate <= art_pkg::RS_SNOOZED;
                                r_rev <= r_rev + 1'b1;
                                r_status <= art_pkg::ST_OK;
                            end
                        end else begin
                            if (w_rev_max) r_status <= art_pkg::ST_NOCAP;
                            else begin
                                r_slot[r_hit_i] <= '0;
                                r_rev <= r_rev + 1'b1;
                                r_status <= art_pkg::ST_OK;
                            end
                        end
                    end
                    art_pkg::OP_ADVANCE, art_pkg::OP_SELECT: r_status <= art_pkg::ST_OK;
                    default: r_status <= art_pkg::ST_INVALID;
                endcase
            end
            // wake due snoozed slots, one a cycle
            if (i_cmd.wake) begin
                r_idx <= o_stat.wake_done ? '0 : r_idx + 1'b1;
                if (w_c.rstate == art_pkg::RS_SNOOZED && r_now >= w_c.snooze_due) begin
                    r_slot[w_i].rstate <= art_pkg::RS_PENDING;
                    r_slot[w_i].snooze_due <= '0;
                    r_rev <= r_rev + 1'b1;
                end
            end
        end
    end

    art_pkg::t_slot w_s;
    assign w_s = r_sel ? w_b : '0;
    assign o_data = {4'd0, r_rev, w_s.missed, w_s.snooze_due, w_s.last_utc,
                     w_s.first_due, w_s.rstate, w_s.occ, w_s.entity, w_s.src,
                     r_sel, r_woken, r_status};
endmodule
`default_nettype wire
